// ===== rtl/core/odo_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the three-encoder odometry block.
// No dependencies; used by the channel interfaces and the top level.
package odo_pkg;

    // CORDIC iterations per sine/cosine evaluation (at most 32, the arctangent table size)
    localparam int CORDIC_STEPS = 24;
    // Conditional subtracts for the 2*pi reduction (quotient stays below 2^7)
    localparam int MOD_STEPS    = 7;
    localparam int DIV_STEPS    = 64;

    localparam int PI_Q24       = 52707179;
    localparam int TWO_PI_Q24   = 105414357;
    localparam int HALF_PI_Q24  = 26353589;
    localparam int GAIN_Q30     = 652032874;
    localparam int ONE_Q30      = 1073741824;
    localparam int TINY_TURN    = 131072;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_INCH_PER_TICK = 2'd0;
    localparam logic [1:0] REG_LEFT_OFFSET   = 2'd1;
    localparam logic [1:0] REG_RIGHT_OFFSET  = 2'd2;
    localparam logic [1:0] REG_BACK_OFFSET   = 2'd3;

    localparam logic [23:0] INCH_PER_TICK_RST = 24'd402624;
    localparam logic [23:0] LEFT_OFFSET_RST   = 24'd309620;
    localparam logic [23:0] RIGHT_OFFSET_RST  = 24'd309620;
    localparam logic [23:0] BACK_OFFSET_RST   = 24'd283818;

    // Arctangent of 2^-i in unsigned Q0.30
    localparam logic [29:0] ATAN_Q30 [0:31] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
    };

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DIST   = 13'b0000000000010,
        S_DSET   = 13'b0000000000100,
        S_DIV    = 13'b0000000001000,
        S_DIVEND = 13'b0000000010000,
        S_KSEL   = 13'b0000000100000,
        S_MOD    = 13'b0000001000000,
        S_FOLD   = 13'b0000010000000,
        S_CORD   = 13'b0000100000000,
        S_CEND   = 13'b0001000000000,
        S_CHORD  = 13'b0010000000000,
        S_ROT    = 13'b0100000000000,
        S_UPD    = 13'b1000000000000
    } state_t;

    typedef logic signed [31:0] word_t;

    // Saturate a 38-bit sum to the signed 32-bit range
    function automatic word_t sat32(input logic signed [37:0] v);
        word_t r;
        if (v > 38'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -38'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/odo_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channels for encoder counts in and pose out.
// Depends on odo_pkg for the payload word type.
interface odo_count_if;
    logic             valid;
    logic             ready;
    odo_pkg::word_t   left_count;
    odo_pkg::word_t   right_count;
    odo_pkg::word_t   back_count;

    modport source (output valid, output left_count, output right_count,
                    output back_count, input ready);
    modport sink   (input valid, input left_count, input right_count,
                    input back_count, output ready);
endinterface

interface odo_pose_if;
    logic             valid;
    logic             ready;
    odo_pkg::word_t   x_pos;
    odo_pkg::word_t   y_pos;
    odo_pkg::word_t   heading;

    modport source (output valid, output x_pos, output y_pos, output heading,
                    input ready);
    modport sink   (input valid, input x_pos, input y_pos, input heading,
                    output ready);
endinterface

// ===== rtl/core/three_encoder_odometry.sv =====
`timescale 1ns / 1ps
// Three tracking-wheel arc odometry: sequencer, shared multiplier, divider, CORDIC.
// Depends on odo_pkg and the channel interfaces in odo_if.sv.
//
// One count beat in, one pose beat out. The block works on one beat at a time
// and drops ready from acceptance until the pose is loaded into the output
// register; a waiting pose does not block the next count beat. A finished
// pose waits in S_UPD until the output register is free. The radix-2 divider
// takes 64 steps per quotient (one for the heading change, one for the chord
// ratio), the CORDIC takes 24 steps per sine/cosine (once for the half angle,
// once for the mid-arc heading), the 2*pi reduction 7 steps, and the single
// 35x35 multiplier issues the eleven products one per cycle, each result
// registered and used on the next cycle.
// Configuration may be written while no beat is in progress.
module three_encoder_odometry (
    input  logic                clk,
    input  logic                rst_n,
    odo_count_if.sink           counts,
    odo_pose_if.source          pose,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    odo_pkg::state_t state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;

    logic [23:0] ipt_reg, lo_reg, ro_reg, bo_reg;
    logic [31:0] prev_l_reg, prev_l_next, prev_r_reg, prev_r_next;
    logic [31:0] prev_b_reg, prev_b_next;
    odo_pkg::word_t pose_x_reg, pose_x_next, pose_y_reg, pose_y_next;
    odo_pkg::word_t pose_h_reg, pose_h_next;

    logic signed [31:0] tl_reg, tl_next, tr_reg, tr_next, tb_reg, tb_next;
    logic signed [33:0] dl_reg, dl_next, dr_reg, dr_next, db_reg, db_next;
    logic signed [31:0] dth_reg, dth_next, k_reg, k_next;
    logic signed [34:0] s2_reg, s2_next, h_reg, h_next, h2_reg, h2_next;
    logic signed [33:0] sp_reg, sp_next, cp_reg, cp_next;
    logic signed [37:0] nx_reg, nx_next, ny_reg, ny_next;

    logic [63:0] dq_reg, dq_next;
    logic [31:0] drem_reg, drem_next, ddiv_reg, ddiv_next;
    logic        dneg_reg, dneg_next, divk_reg, divk_next;

    logic [32:0] am_reg, am_next;
    logic        aneg_reg, aneg_next, cmid_reg, cmid_next;
    logic signed [33:0] cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic        cneg_reg, cneg_next;

    logic signed [34:0] mul_a, mul_b;
    logic signed [69:0] prod_reg;

    odo_pkg::word_t out_x_reg, out_x_next, out_y_reg, out_y_next;
    odo_pkg::word_t out_h_reg, out_h_next;
    logic        out_valid_reg, out_valid_next;

    // product views: rounded distance and Q30 rescale
    logic signed [69:0] dist_rnd, dist_sh, dist_clip;
    logic signed [33:0] dist_val;
    logic signed [69:0] p30_full;
    logic signed [35:0] p30_w;

    always_comb
    begin
        dist_rnd = prod_reg + 70'sd128;
        dist_sh  = dist_rnd >>> 8;
        if (dist_sh > 70'sd4294967296)
            dist_clip = 70'sd4294967296;
        else if (dist_sh < -70'sd4294967296)
            dist_clip = -70'sd4294967296;
        else
            dist_clip = dist_sh;
        dist_val = dist_clip[33:0];
        p30_full = prod_reg >>> 30;
        p30_w    = p30_full[35:0];
    end

    assign counts.ready  = (state_reg == odo_pkg::S_IDLE);
    assign pose.valid    = out_valid_reg;
    assign pose.x_pos    = out_x_reg;
    assign pose.y_pos    = out_y_reg;
    assign pose.heading  = out_h_reg;

    // Sequencer and datapath next-state
    always_comb
    begin
        logic [32:0] trial;
        logic signed [34:0] diff, s2v;
        logic [34:0] mag35;
        logic [24:0] den;
        logic [63:0] lim, qm, res64;
        logic signed [32:0] ang;
        logic [33:0] mstep;
        logic [2:0]  msh;
        logic signed [33:0] a, dx, dy, at;
        logic        fneg;
        logic signed [33:0] sv, cv;
        logic signed [37:0] hsum;

        state_next = state_reg;
        cnt_next = cnt_reg;
        prev_l_next = prev_l_reg;
        prev_r_next = prev_r_reg;
        prev_b_next = prev_b_reg;
        pose_x_next = pose_x_reg;
        pose_y_next = pose_y_reg;
        pose_h_next = pose_h_reg;
        tl_next = tl_reg;
        tr_next = tr_reg;
        tb_next = tb_reg;
        dl_next = dl_reg;
        dr_next = dr_reg;
        db_next = db_reg;
        dth_next = dth_reg;
        k_next = k_reg;
        s2_next = s2_reg;
        h_next = h_reg;
        h2_next = h2_reg;
        sp_next = sp_reg;
        cp_next = cp_reg;
        nx_next = nx_reg;
        ny_next = ny_reg;
        dq_next = dq_reg;
        drem_next = drem_reg;
        ddiv_next = ddiv_reg;
        dneg_next = dneg_reg;
        divk_next = divk_reg;
        am_next = am_reg;
        aneg_next = aneg_reg;
        cmid_next = cmid_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        cneg_next = cneg_reg;
        out_x_next = out_x_reg;
        out_y_next = out_y_reg;
        out_h_next = out_h_reg;
        out_valid_next = out_valid_reg;
        mul_a = '0;
        mul_b = '0;
        trial = '0;
        diff = '0;
        s2v = '0;
        mag35 = '0;
        den = '0;
        lim = '0;
        qm = '0;
        res64 = '0;
        ang = '0;
        mstep = '0;
        msh = '0;
        a = '0;
        dx = '0;
        dy = '0;
        at = '0;
        fneg = 1'b0;
        sv = '0;
        cv = '0;
        hsum = '0;

        // drop the output beat once taken
        if (out_valid_reg && pose.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            odo_pkg::S_IDLE:
            begin
                // take counts, form wrapped deltas
                if (counts.valid)
                begin
                    tl_next = counts.left_count - $signed(prev_l_reg);
                    tr_next = counts.right_count - $signed(prev_r_reg);
                    tb_next = counts.back_count - $signed(prev_b_reg);
                    prev_l_next = counts.left_count;
                    prev_r_next = counts.right_count;
                    prev_b_next = counts.back_count;
                    cnt_next = '0;
                    state_next = odo_pkg::S_DIST;
                end
            end

            odo_pkg::S_DIST:
            begin
                // scale ticks to inches, one product per cycle
                case (cnt_reg[1:0])
                    2'd0: mul_a = {{3{tl_reg[31]}}, tl_reg};
                    2'd1: mul_a = {{3{tr_reg[31]}}, tr_reg};
                    2'd2: mul_a = {{3{tb_reg[31]}}, tb_reg};
                    default: mul_a = '0;
                endcase
                mul_b = $signed({11'b0, ipt_reg});
                case (cnt_reg[1:0])
                    2'd1: dl_next = dist_val;
                    2'd2: dr_next = dist_val;
                    2'd3: db_next = dist_val;
                    default: ;
                endcase
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg[1:0] == 2'd3)
                    state_next = odo_pkg::S_DSET;
            end

            odo_pkg::S_DSET:
            begin
                // heading change: (dL - dR) * 2^24 / spacing
                diff = {dl_reg[33], dl_reg} - {dr_reg[33], dr_reg};
                mag35 = diff[34] ? 35'(-diff) : 35'(diff);
                den = {1'b0, lo_reg} + {1'b0, ro_reg};
                if (den == 25'd0)
                begin
                    dth_next = '0;
                    state_next = odo_pkg::S_KSEL;
                end
                else
                begin
                    dq_next = {5'b0, mag35, 24'b0};
                    drem_next = '0;
                    ddiv_next = {7'b0, den};
                    dneg_next = diff[34];
                    divk_next = 1'b0;
                    cnt_next = '0;
                    state_next = odo_pkg::S_DIV;
                end
            end

            odo_pkg::S_DIV:
            begin
                // one quotient bit per cycle
                trial = {drem_reg, dq_reg[63]};
                if (trial >= {1'b0, ddiv_reg})
                begin
                    drem_next = 32'(trial - {1'b0, ddiv_reg});
                    dq_next = {dq_reg[62:0], 1'b1};
                end
                else
                begin
                    drem_next = trial[31:0];
                    dq_next = {dq_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(odo_pkg::DIV_STEPS - 1))
                    state_next = odo_pkg::S_DIVEND;
            end

            odo_pkg::S_DIVEND:
            begin
                // apply sign, clamp to the target range
                if (divk_reg)
                    lim = 64'(odo_pkg::ONE_Q30);
                else if (dneg_reg)
                    lim = 64'h8000_0000;
                else
                    lim = 64'h7fff_ffff;
                qm = (dq_reg > lim) ? lim : dq_reg;
                res64 = dneg_reg ? 64'(-qm) : qm;
                if (divk_reg)
                begin
                    k_next = res64[31:0];
                    cnt_next = '0;
                    state_next = odo_pkg::S_CHORD;
                end
                else
                begin
                    dth_next = res64[31:0];
                    state_next = odo_pkg::S_KSEL;
                end
            end

            odo_pkg::S_KSEL:
            begin
                // pick straight, tiny-turn or full arc path
                if (dth_reg == 32'sd0)
                begin
                    k_next = 32'(odo_pkg::ONE_Q30);
                    s2_next = '0;
                    cnt_next = '0;
                    state_next = odo_pkg::S_CHORD;
                end
                else if (dth_reg > -32'(odo_pkg::TINY_TURN) &&
                         dth_reg < 32'(odo_pkg::TINY_TURN))
                begin
                    k_next = 32'(odo_pkg::ONE_Q30);
                    s2_next = $signed({{3{dth_reg[31]}}, dth_reg}) <<< 6;
                    cnt_next = '0;
                    state_next = odo_pkg::S_CHORD;
                end
                else
                begin
                    ang = $signed({dth_reg[31], dth_reg}) >>> 1;
                    am_next = ang[32] ? 33'(-ang) : 33'(ang);
                    aneg_next = ang[32];
                    cmid_next = 1'b0;
                    cnt_next = '0;
                    state_next = odo_pkg::S_MOD;
                end
            end

            odo_pkg::S_MOD:
            begin
                // reduce magnitude modulo 2*pi, largest multiple first
                msh = 3'(odo_pkg::MOD_STEPS - 1) - cnt_reg[2:0];
                mstep = 34'(odo_pkg::TWO_PI_Q24) << msh;
                if ({1'b0, am_reg} >= mstep)
                    am_next = 33'({1'b0, am_reg} - mstep);
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(odo_pkg::MOD_STEPS - 1))
                    state_next = odo_pkg::S_FOLD;
            end

            odo_pkg::S_FOLD:
            begin
                // fold into [-pi/2, pi/2] and seed the rotation
                a = aneg_reg ? -$signed({1'b0, am_reg}) : $signed({1'b0, am_reg});
                if (a > 34'(odo_pkg::PI_Q24))
                    a = a - 34'(odo_pkg::TWO_PI_Q24);
                if (a < -34'(odo_pkg::PI_Q24))
                    a = a + 34'(odo_pkg::TWO_PI_Q24);
                fneg = 1'b0;
                if (a > 34'(odo_pkg::HALF_PI_Q24))
                begin
                    a = a - 34'(odo_pkg::PI_Q24);
                    fneg = 1'b1;
                end
                else if (a < -34'(odo_pkg::HALF_PI_Q24))
                begin
                    a = a + 34'(odo_pkg::PI_Q24);
                    fneg = 1'b1;
                end
                cneg_next = fneg;
                cz_next = a <<< 6;
                cx_next = 34'(odo_pkg::GAIN_Q30);
                cy_next = '0;
                cnt_next = '0;
                state_next = odo_pkg::S_CORD;
            end

            odo_pkg::S_CORD:
            begin
                // one micro-rotation per cycle
                dx = cy_reg >>> cnt_reg[4:0];
                dy = cx_reg >>> cnt_reg[4:0];
                at = $signed({4'b0, odo_pkg::ATAN_Q30[cnt_reg[4:0]]});
                if (cz_reg >= 34'sd0)
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - at;
                end
                else
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + at;
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(odo_pkg::CORDIC_STEPS - 1))
                    state_next = odo_pkg::S_CEND;
            end

            odo_pkg::S_CEND:
            begin
                sv = cneg_reg ? -cy_reg : cy_reg;
                cv = cneg_reg ? -cx_reg : cx_reg;
                if (cmid_reg)
                begin
                    sp_next = sv;
                    cp_next = cv;
                    cnt_next = '0;
                    state_next = odo_pkg::S_ROT;
                end
                else
                begin
                    // chord ratio: 2*sin(half) * 2^24 / dtheta
                    s2v = {sv, 1'b0};
                    s2_next = s2v;
                    mag35 = s2v[34] ? 35'(-s2v) : 35'(s2v);
                    dq_next = {5'b0, mag35, 24'b0};
                    drem_next = '0;
                    ddiv_next = dth_reg[31] ? 32'(-dth_reg) : 32'(dth_reg);
                    dneg_next = s2v[34] ^ dth_reg[31];
                    divk_next = 1'b1;
                    cnt_next = '0;
                    state_next = odo_pkg::S_DIV;
                end
            end

            odo_pkg::S_CHORD:
            begin
                // forward and sideways chords
                case (cnt_reg[2:0])
                    3'd0:
                    begin
                        mul_a = {dr_reg[33], dr_reg};
                        mul_b = {{3{k_reg[31]}}, k_reg};
                    end
                    3'd1:
                    begin
                        mul_a = $signed({11'b0, ro_reg});
                        mul_b = s2_reg;
                    end
                    3'd2:
                    begin
                        mul_a = {db_reg[33], db_reg};
                        mul_b = {{3{k_reg[31]}}, k_reg};
                    end
                    3'd3:
                    begin
                        mul_a = $signed({11'b0, bo_reg});
                        mul_b = s2_reg;
                    end
                    default: ;
                endcase
                case (cnt_reg[2:0])
                    3'd1: h_next = p30_w[34:0];
                    3'd2: h_next = 35'(h_reg + p30_w);
                    3'd3: h2_next = p30_w[34:0];
                    3'd4: h2_next = 35'(h2_reg + p30_w);
                    default: ;
                endcase
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg[2:0] == 3'd4)
                begin
                    // mid-arc heading next
                    ang = $signed({pose_h_reg[31], pose_h_reg}) +
                          ($signed({dth_reg[31], dth_reg}) >>> 1);
                    am_next = ang[32] ? 33'(-ang) : 33'(ang);
                    aneg_next = ang[32];
                    cmid_next = 1'b1;
                    cnt_next = '0;
                    state_next = odo_pkg::S_MOD;
                end
            end

            odo_pkg::S_ROT:
            begin
                // rotate chords into the field frame
                case (cnt_reg[2:0])
                    3'd0:
                    begin
                        mul_a = h_reg;
                        mul_b = {cp_reg[33], cp_reg};
                    end
                    3'd1:
                    begin
                        mul_a = h2_reg;
                        mul_b = {sp_reg[33], sp_reg};
                    end
                    3'd2:
                    begin
                        mul_a = h_reg;
                        mul_b = {sp_reg[33], sp_reg};
                    end
                    3'd3:
                    begin
                        mul_a = h2_reg;
                        mul_b = {cp_reg[33], cp_reg};
                    end
                    default: ;
                endcase
                case (cnt_reg[2:0])
                    3'd1: ny_next = $signed({{6{pose_y_reg[31]}}, pose_y_reg}) +
                                    {{2{p30_w[35]}}, p30_w};
                    3'd2: ny_next = ny_reg - {{2{p30_w[35]}}, p30_w};
                    3'd3: nx_next = $signed({{6{pose_x_reg[31]}}, pose_x_reg}) +
                                    {{2{p30_w[35]}}, p30_w};
                    3'd4: nx_next = nx_reg + {{2{p30_w[35]}}, p30_w};
                    default: ;
                endcase
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg[2:0] == 3'd4)
                    state_next = odo_pkg::S_UPD;
            end

            odo_pkg::S_UPD:
            begin
                // commit pose, load output once the slot is free
                if (!out_valid_reg || pose.ready)
                begin
                    hsum = $signed({{6{pose_h_reg[31]}}, pose_h_reg}) +
                           $signed({{6{dth_reg[31]}}, dth_reg});
                    pose_x_next = odo_pkg::sat32(nx_reg);
                    pose_y_next = odo_pkg::sat32(ny_reg);
                    pose_h_next = odo_pkg::sat32(hsum);
                    out_x_next = odo_pkg::sat32(nx_reg);
                    out_y_next = odo_pkg::sat32(ny_reg);
                    out_h_next = odo_pkg::sat32(hsum);
                    out_valid_next = 1'b1;
                    state_next = odo_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = odo_pkg::S_IDLE;
            end
        endcase
    end

    // Control, configuration and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= odo_pkg::S_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            divk_reg <= 1'b0;
            cmid_reg <= 1'b0;
            ipt_reg <= odo_pkg::INCH_PER_TICK_RST;
            lo_reg <= odo_pkg::LEFT_OFFSET_RST;
            ro_reg <= odo_pkg::RIGHT_OFFSET_RST;
            bo_reg <= odo_pkg::BACK_OFFSET_RST;
            prev_l_reg <= '0;
            prev_r_reg <= '0;
            prev_b_reg <= '0;
            pose_x_reg <= '0;
            pose_y_reg <= '0;
            pose_h_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
            divk_reg <= divk_next;
            cmid_reg <= cmid_next;
            prev_l_reg <= prev_l_next;
            prev_r_reg <= prev_r_next;
            prev_b_reg <= prev_b_next;
            pose_x_reg <= pose_x_next;
            pose_y_reg <= pose_y_next;
            pose_h_reg <= pose_h_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    odo_pkg::REG_INCH_PER_TICK: ipt_reg <= cfg_data;
                    odo_pkg::REG_LEFT_OFFSET:   lo_reg <= cfg_data;
                    odo_pkg::REG_RIGHT_OFFSET:  ro_reg <= cfg_data;
                    odo_pkg::REG_BACK_OFFSET:   bo_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        tl_reg <= tl_next;
        tr_reg <= tr_next;
        tb_reg <= tb_next;
        dl_reg <= dl_next;
        dr_reg <= dr_next;
        db_reg <= db_next;
        dth_reg <= dth_next;
        k_reg <= k_next;
        s2_reg <= s2_next;
        h_reg <= h_next;
        h2_reg <= h2_next;
        sp_reg <= sp_next;
        cp_reg <= cp_next;
        nx_reg <= nx_next;
        ny_reg <= ny_next;
        dq_reg <= dq_next;
        drem_reg <= drem_next;
        ddiv_reg <= ddiv_next;
        dneg_reg <= dneg_next;
        am_reg <= am_next;
        aneg_reg <= aneg_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
        cneg_reg <= cneg_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_h_reg <= out_h_next;
    end

`ifndef SYNTHESIS
    // an accepted beat keeps the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (counts.valid && counts.ready) |=> !counts.ready)
        else $error("count beat accepted while busy");

    // chord ratio stays within +-1.0 when used
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == odo_pkg::S_CHORD) |->
        (k_reg <= 32'sd1073741824 && k_reg >= -32'sd1073741824))
        else $error("chord ratio out of range");

    // a committed pose shows on the output and frees the input
    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == odo_pkg::S_UPD && (!out_valid_reg || pose.ready)) |=>
        (pose.valid && counts.ready))
        else $error("pose commit lost");
`endif

endmodule
